// ===== src/dac_waveform_generator_macros.svh =====
// Assertion macros used by the top level of the waveform generator.
`ifndef DAC_WAVEFORM_GENERATOR_MACROS_SVH
`define DAC_WAVEFORM_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define DWG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dac waveform generator check failed");
`define DWG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dac waveform generator check failed");
`else
`define DWG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DWG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/dwg_pkg.sv =====
// Types, register codes and constant lookup tables of the waveform generator.
package dwg_pkg;

    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SHAPE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_ENABLE = 3'd4;

    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;
    localparam logic [1:0] SHAPE_SAWTOOTH = 2'd3;

    localparam logic [5:0]  AMP_MAX      = 6'd33;
    localparam logic [6:0]  DUTY_MAX     = 7'd100;
    localparam logic [6:0]  DUTY_RESET   = 7'd50;
    localparam logic [14:0] FREQ_MAX     = 15'd20000;
    localparam logic [11:0] MID_CODE     = 12'd2048;
    localparam logic [10:0] WAVE_FULL    = 11'd2000;
    localparam logic [6:0]  LAST_SAMPLE  = 7'd127;

    // Division by 2000 is a shift by four and a reciprocal multiply for 125.
    localparam int          RECIP_SHIFT  = 26;
    localparam logic [19:0] RECIP_125    = 20'(((1 << RECIP_SHIFT) + 124) / 125);

    typedef struct packed {
        logic [1:0]  wave_shape;
        logic [5:0]  amplitude_tenths_volt;
        logic [6:0]  duty_pct;
        logic [14:0] frequency_tenths_hz;
        logic        run_enable;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic scale;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    typedef logic [0:63][10:0]  sine_lut_t;
    typedef logic [127:0][10:0] wave_lut_t;
    typedef logic [127:0][7:0]  thr_lut_t;
    typedef logic [63:0][11:0]  code_lut_t;

    // Sine wave offset by +1000, one entry per pair of samples.
    localparam sine_lut_t SINE_OFFSET = '{
        11'd1000, 11'd1098, 11'd1195, 11'd1290, 11'd1383, 11'd1471, 11'd1556, 11'd1634,
        11'd1707, 11'd1773, 11'd1831, 11'd1882, 11'd1924, 11'd1957, 11'd1981, 11'd1995,
        11'd2000, 11'd1995, 11'd1981, 11'd1957, 11'd1924, 11'd1882, 11'd1831, 11'd1773,
        11'd1707, 11'd1634, 11'd1556, 11'd1471, 11'd1383, 11'd1290, 11'd1195, 11'd1098,
        11'd1000, 11'd902,  11'd805,  11'd710,  11'd617,  11'd529,  11'd444,  11'd366,
        11'd293,  11'd227,  11'd169,  11'd118,  11'd76,   11'd43,   11'd19,   11'd5,
        11'd0,    11'd5,    11'd19,   11'd43,   11'd76,   11'd118,  11'd169,  11'd227,
        11'd293,  11'd366,  11'd444,  11'd529,  11'd617,  11'd710,  11'd805,  11'd902
    };

    function automatic wave_lut_t build_triangle_lut();
        wave_lut_t t;
        for (int i = 0; i < 128; i++) begin
            if (i < 64) begin
                t[i] = 11'((i * 2000) / 63);
            end else begin
                t[i] = 11'(2000 - ((i - 64) * 2000) / 63);
            end
        end
        return t;
    endfunction

    function automatic wave_lut_t build_sawtooth_lut();
        wave_lut_t t;
        for (int i = 0; i < 128; i++) begin
            t[i] = 11'((i * 2000) / 127);
        end
        return t;
    endfunction

    function automatic thr_lut_t build_threshold_lut();
        thr_lut_t t;
        for (int i = 0; i < 128; i++) begin
            t[i] = 8'((i * 128 + 99) / 100);
        end
        return t;
    endfunction

    function automatic code_lut_t build_low_lut();
        code_lut_t t;
        int        a;
        int        vpp;
        for (int i = 0; i < 64; i++) begin
            a    = (i > 33) ? 33 : i;
            vpp  = (a * 4095) / 33;
            t[i] = 12'(2048 - vpp / 2);
        end
        return t;
    endfunction

    function automatic code_lut_t build_span_lut();
        code_lut_t t;
        int        a;
        int        vpp;
        int        lo;
        int        hi;
        for (int i = 0; i < 64; i++) begin
            a    = (i > 33) ? 33 : i;
            vpp  = (a * 4095) / 33;
            lo   = 2048 - vpp / 2;
            hi   = 2048 + (vpp + 1) / 2;
            hi   = (hi > 4095) ? 4095 : hi;
            t[i] = 12'(hi - lo);
        end
        return t;
    endfunction

    localparam wave_lut_t TRIANGLE_OFFSET = build_triangle_lut();
    localparam wave_lut_t SAWTOOTH_OFFSET = build_sawtooth_lut();
    localparam thr_lut_t  DUTY_THRESHOLD  = build_threshold_lut();
    localparam code_lut_t CODE_FLOOR      = build_low_lut();
    localparam code_lut_t CODE_SPAN       = build_span_lut();

endpackage

// ===== src/dwg_cfg_regs.sv =====
// Configuration register file with write saturation.
module dwg_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dwg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dwg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dwg_pkg::cfg_t                   cfg
);
    import dwg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WAVE_SHAPE: cfg_next.wave_shape = cfg_data[1:0];
                REG_AMPLITUDE:
                    cfg_next.amplitude_tenths_volt =
                        (cfg_data[5:0] > AMP_MAX) ? AMP_MAX : cfg_data[5:0];
                REG_DUTY:
                    cfg_next.duty_pct =
                        (cfg_data[6:0] > DUTY_MAX) ? DUTY_MAX : cfg_data[6:0];
                REG_FREQUENCY:
                    cfg_next.frequency_tenths_hz =
                        (cfg_data > FREQ_MAX) ? FREQ_MAX : cfg_data;
                REG_RUN_ENABLE: cfg_next.run_enable = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_shape            <= SHAPE_SINE;
            cfg_reg.amplitude_tenths_volt <= '0;
            cfg_reg.duty_pct              <= DUTY_RESET;
            cfg_reg.frequency_tenths_hz   <= '0;
            cfg_reg.run_enable            <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/dwg_ctrl.sv =====
// Controller state machine sequencing one sample through the datapath.
module dwg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dwg_pkg::dp_status_t status,
    output dwg_pkg::dp_cmd_t    cmd
);
    import dwg_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!status.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/dwg_datapath.sv =====
// Sample datapath: wave lookup, scaling onto the code range and output register.
module dwg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  dwg_pkg::cfg_t       cfg,
    input  dwg_pkg::dp_cmd_t    cmd,
    output dwg_pkg::dp_status_t status,
    input  logic                phase_restart,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [11:0]         dac_code,
    output logic [6:0]          sample_position,
    output logic                period_end
);
    import dwg_pkg::*;

    logic [6:0]  phase_reg;
    logic [6:0]  phase_next;
    logic [6:0]  idx_reg;
    logic        hold_reg;
    logic [10:0] wave_reg;
    logic [11:0] low_reg;
    logic [11:0] span_reg;
    logic [22:0] prod_reg;
    logic [11:0] quot_reg;
    logic        out_valid_reg;
    logic [11:0] dac_code_reg;
    logic [6:0]  sample_position_reg;
    logic        period_end_reg;

    logic [6:0]  idx;
    logic [10:0] wave;
    logic [38:0] recip_prod;

    assign idx = phase_restart ? 7'd0 : phase_reg;

    always_comb
    begin
        case (cfg.wave_shape)
            SHAPE_SQUARE:
                wave = ({1'b0, idx} < DUTY_THRESHOLD[cfg.duty_pct]) ? WAVE_FULL : 11'd0;
            SHAPE_TRIANGLE: wave = TRIANGLE_OFFSET[idx];
            SHAPE_SAWTOOTH: wave = SAWTOOTH_OFFSET[idx];
            default:        wave = SINE_OFFSET[idx[6:1]];
        endcase
    end

    assign recip_prod = 39'(prod_reg[22:4]) * 39'(RECIP_125);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= idx;
            hold_reg <= !cfg.run_enable || (cfg.frequency_tenths_hz == '0);
            wave_reg <= wave;
            low_reg  <= CODE_FLOOR[cfg.amplitude_tenths_volt];
            span_reg <= CODE_SPAN[cfg.amplitude_tenths_volt];
        end
        if (cmd.mul)
        begin
            prod_reg <= 23'(wave_reg) * 23'(span_reg);
        end
        if (cmd.scale)
        begin
            quot_reg <= recip_prod[RECIP_SHIFT+11:RECIP_SHIFT];
        end
        if (cmd.load)
        begin
            dac_code_reg        <= hold_reg ? MID_CODE : low_reg + quot_reg;
            sample_position_reg <= idx_reg;
            period_end_reg      <= !hold_reg && (idx_reg == LAST_SAMPLE);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (cmd.load)
        begin
            phase_next = hold_reg ? idx_reg : idx_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign dac_code        = dac_code_reg;
    assign sample_position = sample_position_reg;
    assign period_end      = period_end_reg;

endmodule

// ===== src/dac_waveform_generator.sv =====
// Top level of the DAC waveform generator.
// Each request is one sample tick and yields one result: a 12-bit DAC code, the phase index
// it was taken at and a flag on the last sample of the 128-sample period. A sample passes
// four steps from acceptance to the output register: capture with table lookup,
// the wave-times-span multiply, the reciprocal multiply that divides by 2000, and the
// output load. The load waits while the previous result is still held unread, and a new
// sample is accepted only after the last one has been loaded. Configuration is written through
// the plain write port by the user only while the block is idle; the block does not enforce it.
`include "dac_waveform_generator_macros.svh"

module dac_waveform_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dwg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dwg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            phase_restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [11:0]                     dac_code,
    output logic [6:0]                      sample_position,
    output logic                            period_end
);
    import dwg_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    dwg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dwg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dwg_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .phase_restart   (phase_restart),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .dac_code        (dac_code),
        .sample_position (sample_position),
        .period_end      (period_end)
    );

    `DWG_ASSERT_NXT(a_one_request_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    `DWG_ASSERT_NXT(a_load_shows_result, clk, rst_n, cmd.load, out_valid)
    `DWG_ASSERT_IMP(a_period_end_at_last, clk, rst_n, out_valid && period_end, &sample_position)

endmodule
